// ===== sv/bgcd_pkg.sv =====
// Package for the binary GCD core.
// Holds the default datapath width and the width of the operand and result ports.
// No dependencies.
package bgcd_pkg;

    localparam int DEFAULT_WIDTH = 32;  // datapath width
    localparam int FIELD_W       = 32;  // width of the operand and divisor ports

endpackage

// ===== sv/bgcd_step.sv =====
// One reduction step of the binary GCD pipeline, registered at its output.
// Depends on bgcd_pkg for the default width.
module bgcd_step #(
    parameter int WIDTH = bgcd_pkg::DEFAULT_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [WIDTH-1:0]         i_a,
    input  logic [WIDTH-1:0]         i_b,
    input  logic [$clog2(WIDTH)-1:0] i_k,
    output logic                     o_valid,
    output logic [WIDTH-1:0]         o_a,
    output logic [WIDTH-1:0]         o_b,
    output logic [$clog2(WIDTH)-1:0] o_k
);
    localparam int KW = $clog2(WIDTH);

    logic             r_valid;
    logic [WIDTH-1:0] r_a, r_b, n_a, n_b;
    logic [KW-1:0]    r_k, n_k;
    logic [WIDTH-1:0] diff;
    logic             a_gt;

    assign a_gt = i_a > i_b;
    assign diff = a_gt ? (i_a - i_b) : (i_b - i_a);

    // Each step at least halves a*b until b reaches zero; a stays nonzero
    // unless both operands were zero.
    always_comb begin
        n_a = i_a;
        n_b = i_b;
        n_k = i_k;
        priority if (i_b == '0) begin
            n_a = i_a;
        end else if (!i_a[0] && !i_b[0]) begin
            n_a = i_a >> 1;
            n_b = i_b >> 1;
            n_k = KW'(i_k + 1'b1);
        end else if (!i_a[0]) begin
            n_a = i_a >> 1;
        end else if (!i_b[0]) begin
            n_b = i_b >> 1;
        end else begin
            // both odd: keep the smaller, halve the even difference
            n_a = a_gt ? i_b : i_a;
            n_b = diff >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= n_a;
            r_b <= n_b;
            r_k <= n_k;
        end
    end

    assign o_valid = r_valid;
    assign o_a     = r_a;
    assign o_b     = r_b;
    assign o_k     = r_k;

endmodule

// ===== sv/binary_gcd_core.sv =====
// Binary GCD core (Stein's method), fully pipelined.
// Depends on bgcd_pkg and bgcd_step.
//
// Usage:
//   Input channel: i_operand_a, i_operand_b with i_in_valid / o_in_ready.
//   Output channel: o_divisor with o_out_valid / i_out_ready.
//   A request is taken on a clock edge where valid and ready are both high.
//   Operands are reduced to their low WIDTH bits; gcd(0, x) = x, gcd(0, 0) = 0.
//
// Throughput: one request per cycle while no result waits untaken at the output.
// The request lands in the entry register at the accepting edge, then passes
// 2*WIDTH reduction steps (each a compare, a subtract and a one-bit shift) and
// one register for the final shift by the common power of two.
//
// The whole pipeline advances together: when the output register holds a
// result that is not taken, every stage freezes and o_in_ready drops, so
// nothing is lost or repeated.
// Reset (synchronous, active low) clears all valid bits; data registers are
// left as they are.
module binary_gcd_core #(
    parameter int WIDTH = bgcd_pkg::DEFAULT_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [bgcd_pkg::FIELD_W-1:0] i_operand_a,
    input  logic [bgcd_pkg::FIELD_W-1:0] i_operand_b,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [bgcd_pkg::FIELD_W-1:0] o_divisor
);
    import bgcd_pkg::*;

    localparam int KW    = $clog2(WIDTH);
    localparam int NSTEP = 2 * WIDTH;

    logic             en;
    logic [WIDTH-1:0] op_a, op_b;

    logic             w_valid [0:NSTEP];
    logic [WIDTH-1:0] w_a     [0:NSTEP];
    logic [WIDTH-1:0] w_b     [0:NSTEP];
    logic [KW-1:0]    w_k     [0:NSTEP];

    logic             r_in_valid;
    logic [WIDTH-1:0] r_in_a, r_in_b;
    logic             r_out_valid;
    logic [WIDTH-1:0] r_div;

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    assign op_a = WIDTH'(i_operand_a);
    assign op_b = WIDTH'(i_operand_b);

    // Entry stage: put the nonzero operand in a, so a is zero only when both operands are.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (op_a == '0) begin
                r_in_a <= op_b;
                r_in_b <= '0;
            end else begin
                r_in_a <= op_a;
                r_in_b <= op_b;
            end
        end
    end

    assign w_valid[0] = r_in_valid;
    assign w_a[0]     = r_in_a;
    assign w_b[0]     = r_in_b;
    assign w_k[0]     = '0;

    for (genvar s = 0; s < NSTEP; s++) begin : g_step
        bgcd_step #(
            .WIDTH (WIDTH)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_valid[s]),
            .i_a     (w_a[s]),
            .i_b     (w_b[s]),
            .i_k     (w_k[s]),
            .o_valid (w_valid[s+1]),
            .o_a     (w_a[s+1]),
            .o_b     (w_b[s+1]),
            .o_k     (w_k[s+1])
        );
    end

    // Output register: restore the common power of two.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= w_valid[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_div <= w_a[NSTEP] << w_k[NSTEP];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_divisor   = FIELD_W'(r_div);

    // The reduction must be finished by the last step.
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[NSTEP] |-> (w_b[NSTEP] == '0))
        else $error("gcd reduction not finished at last step");

    // An accepted request lands in the entry stage.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_in_valid)
        else $error("accepted request did not enter the pipeline");

    // A frozen pipeline keeps the result about to be loaded.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en && w_valid[NSTEP]) |=> (w_valid[NSTEP] && $stable(w_a[NSTEP])
                                     && $stable(w_k[NSTEP])))
        else $error("last step changed during stall");

    // A nonzero a entering the first step stays nonzero after it.
    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && w_valid[0] && (w_a[0] != '0)) |=> (w_a[1] != '0))
        else $error("nonzero operand vanished in first step");

endmodule

// ===== tb/tb_binary_gcd_core.sv =====
// Self-checking testbench for binary_gcd_core: directed table, then random operand pairs.
// Each divisor is compared in order against a typed value or a local Stein GCD predictor.
// Depends on bgcd_pkg and the binary_gcd_core RTL.
`timescale 1ns / 100ps

module tb_binary_gcd_core;

    localparam int FW             = bgcd_pkg::FIELD_W;
    localparam int DW             = bgcd_pkg::DEFAULT_WIDTH;
    localparam int N_RANDOM       = 1700;
    localparam int N_DIRECTED     = 21;
    localparam int IDLE_PCT       = 21;
    localparam int HOLD_AT        = 400;   // requests accepted before the long output stall
    localparam int HOLD_CYCLES    = 300;
    localparam int CALM_FROM      = 1000;  // no idling on either side in this window
    localparam int CALM_TO        = 1300;
    localparam int DRAIN_CYCLES   = 2 * DW + 2 + 80;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [FW-1:0] a;
        logic [FW-1:0] b;
        logic          known;  // div below is typed in, not predicted
        logic [FW-1:0] div;
    } gcd_req_t;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    logic [FW-1:0] i_operand_a = '0;
    logic [FW-1:0] i_operand_b = '0;
    logic          i_out_ready = 1'b0;
    logic          o_in_ready;
    logic          o_out_valid;
    logic [FW-1:0] o_divisor;

    gcd_req_t      req_q[$];
    logic [FW-1:0] divisor_q[$];
    gcd_req_t      dir_rows[N_DIRECTED];

    int err_cnt      = 0;
    int sent_cnt     = 0;
    int checked_cnt  = 0;
    int stall_cnt    = 0;
    int quiet_cycles = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    binary_gcd_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_divisor   (o_divisor)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int trailing_zero_cnt(input logic [63:0] x);
        int n;
        n = 0;
        if (x == 0) return 0;
        while (x[0] == 1'b0) begin
            x = x >> 1;
            n++;
        end
        return n;
    endfunction

    // Stein's binary GCD on the low DW bits of each operand
    function automatic logic [FW-1:0] stein_divisor(input logic [FW-1:0] a_in,
                                                    input logic [FW-1:0] b_in);
        logic [63:0] mask;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] t;
        int          common;
        mask = (DW >= 64) ? ~64'd0 : ((64'd1 << DW) - 1);
        x = 64'(a_in) & mask;
        y = 64'(b_in) & mask;
        if (x == 0) return FW'(y);
        if (y == 0) return FW'(x);
        if (x < y) begin
            t = x; x = y; y = t;
        end
        common = trailing_zero_cnt(x | y);
        x = x >> trailing_zero_cnt(x);
        do begin
            y = y >> trailing_zero_cnt(y);
            if (x > y) begin
                t = x; x = y; y = t;
            end
            y = y - x;
        end while (y != 0);
        return FW'((x << common) & mask);
    endfunction

    function automatic bit calm_window();
        return (sent_cnt >= CALM_FROM) && (sent_cnt < CALM_TO);
    endfunction

    // sender: one nonblocking write per signal per edge
    always @(posedge i_clk) begin
        logic     take;
        logic     next_valid;
        gcd_req_t cur;
        take       = i_in_valid && o_in_ready;
        next_valid = i_in_valid;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_ready) stall_cnt++;
            if (take) begin
                cur = req_q.pop_front();
                divisor_q.push_back(cur.known ? cur.div : stein_divisor(cur.a, cur.b));
                sent_cnt++;
            end
            if (!i_in_valid || take) begin
                if (req_q.size() != 0 &&
                    (calm_window() || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    next_valid = 1'b1;
                    i_operand_a <= req_q[0].a;
                    i_operand_b <= req_q[0].b;
                end else begin
                    next_valid = 1'b0;
                end
            end
        end
        i_in_valid <= next_valid;
    end

    // receiver and checker
    always @(posedge i_clk) begin
        logic [FW-1:0] want;
        logic          next_ready;
        next_ready = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (divisor_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: divisor with no request pending: expected none actual %h",
                             $time, o_divisor);
                end else begin
                    want = divisor_q.pop_front();
                    checked_cnt++;
                    if (o_divisor !== want) begin
                        err_cnt++;
                        $display("%0t: divisor mismatch: expected %h actual %h",
                                 $time, want, o_divisor);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (!hold_done && sent_cnt >= HOLD_AT) begin
                // long back-pressure so the pipeline fills and stalls its input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
            end else begin
                next_ready = calm_window() || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
        i_out_ready <= next_ready;
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d requests pending, %0d divisors due",
                     $time, req_q.size(), divisor_q.size());
            $display("binary_gcd_core verification failed");
            $finish;
        end
    end

    initial begin
        gcd_req_t      r;
        logic [FW-1:0] g;
        int            k;
        // directed table: typed results only for zero and extreme operands
        dir_rows[0]  = '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000};
        dir_rows[1]  = '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF};
        dir_rows[2]  = '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF};
        dir_rows[3]  = '{32'h0000_0000, 32'h0000_0001, 1'b1, 32'h0000_0001};
        dir_rows[4]  = '{32'h8000_0000, 32'h0000_0000, 1'b1, 32'h8000_0000};
        dir_rows[5]  = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF};
        dir_rows[6]  = '{32'h8000_0000, 32'h8000_0000, 1'b1, 32'h8000_0000};
        dir_rows[7]  = '{32'h0000_0001, 32'h0000_0001, 1'b1, 32'h0000_0001};
        dir_rows[8]  = '{32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001};
        dir_rows[9]  = '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'h0000_0001};
        dir_rows[10] = '{32'h0000_000C, 32'h0000_0012, 1'b0, 32'h0};
        dir_rows[11] = '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, 32'h0};
        dir_rows[12] = '{32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0};
        dir_rows[13] = '{32'hC000_0000, 32'h3000_0000, 1'b0, 32'h0};
        dir_rows[14] = '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0};
        dir_rows[15] = '{32'hFFFF_0000, 32'h0000_FFFF, 1'b0, 32'h0};
        dir_rows[16] = '{32'h0000_0002, 32'h0000_0004, 1'b0, 32'h0};
        dir_rows[17] = '{32'hDEAD_BEEF, 32'h1234_5678, 1'b0, 32'h0};
        dir_rows[18] = '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'h0};
        dir_rows[19] = '{32'hF0F0_F0F0, 32'h0F0F_0F0F, 1'b0, 32'h0};
        dir_rows[20] = '{32'h0000_0006, 32'h0000_0003, 1'b0, 32'h0};
        for (int i = 0; i < N_DIRECTED; i++) req_q.push_back(dir_rows[i]);

        for (int i = 0; i < N_RANDOM; i++) begin
            r.known = 1'b0;
            r.div   = '0;
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    r.a = $urandom();
                    r.b = $urandom();
                end
                3, 4: begin  // shared odd-ish factor so the loop runs long
                    g   = $urandom_range(1, 65535);
                    r.a = g * $urandom_range(1, 65535);
                    r.b = g * $urandom_range(1, 65535);
                end
                5: begin  // shared power of two
                    k   = $urandom_range(0, FW - 1);
                    r.a = $urandom() << k;
                    r.b = $urandom() << k;
                end
                6: begin  // one operand zero
                    r.a = $urandom();
                    r.b = '0;
                    if ($urandom_range(0, 1)) begin
                        r.b = r.a;
                        r.a = '0;
                    end
                end
                7: begin  // equal or neighboring operands
                    r.a = $urandom();
                    r.b = r.a + $urandom_range(0, 3);
                end
                8: begin
                    r.a = $urandom_range(0, 255);
                    r.b = $urandom_range(0, 255);
                end
                default: begin  // single bits and all-ones patterns
                    r.a = $urandom_range(0, 1) ? (32'h1 << $urandom_range(0, FW - 1))
                                               : ~(32'h1 << $urandom_range(0, FW - 1));
                    r.b = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom();
                end
            endcase
            req_q.push_back(r);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_q.size() != 0 || divisor_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d operand pairs (%0d from the directed table), checked %0d divisors.",
                 sent_cnt, N_DIRECTED, checked_cnt);
        $display("Input was held off for %0d cycles under output back-pressure.", stall_cnt);
        if (err_cnt == 0) begin
            $display("binary_gcd_core verification clean");
        end else begin
            $display("binary_gcd_core verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/bgcd_pkg.sv
sv/bgcd_step.sv
sv/binary_gcd_core.sv
tb/tb_binary_gcd_core.sv
